>>> sv/tlbpt_pkg.sv
// Shared types, sizes and constant tables for the TLB / page table translator.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package tlbpt_pkg;

  localparam int unsigned TlbEntries = 16;
  localparam int unsigned PageCount  = 256;

  localparam int unsigned TlbIdxW  = $clog2(TlbEntries);
  localparam int unsigned PageIdxW = (PageCount > 1) ? $clog2(PageCount) : 1;

  localparam int unsigned VaW    = 16;
  localparam int unsigned PageW  = 8;
  localparam int unsigned FrameW = 8;
  localparam int unsigned OffsW  = 8;
  localparam int unsigned PageValues = 1 << PageW;

  typedef logic [PageW-1:0]    page_t;
  typedef logic [FrameW-1:0]   frame_t;
  typedef logic [PageIdxW-1:0] pidx_t;
  typedef logic [TlbIdxW-1:0]  tlb_idx_t;

  // Page number to page table index (page number modulo the table depth).
  typedef pidx_t pidx_lut_t [PageValues];

  function automatic pidx_lut_t build_pidx_lut();
    pidx_lut_t lut;
    for (int i = 0; i < PageValues; i++) begin
      lut[i] = PageIdxW'(i % PageCount);
    end
    return lut;
  endfunction

  localparam pidx_lut_t PidxLut = build_pidx_lut();

  // Page table write-back beat.
  typedef struct packed {
    logic   en;
    pidx_t  idx;
    frame_t frame;
  } pt_wr_t;

  // TLB insertion beat.
  typedef struct packed {
    logic   en;
    page_t  page;
    frame_t frame;
  } tlb_ins_t;

  // TLB search result.
  typedef struct packed {
    logic   hit;
    frame_t frame;
  } tlb_res_t;

endpackage

`default_nettype wire

>>> sv/tlbpt_tlb.sv
// Fully associative TLB: register array with valid bits and round-robin fill.
// Depends on tlbpt_pkg for sizes and the insertion / result structs.
`default_nettype none

module tlbpt_tlb (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tlbpt_pkg::page_t    page_i,
  output tlbpt_pkg::tlb_res_t res_o,
  input  tlbpt_pkg::tlb_ins_t ins_i
);

  tlbpt_pkg::page_t    page_q  [tlbpt_pkg::TlbEntries];
  tlbpt_pkg::frame_t   frame_q [tlbpt_pkg::TlbEntries];
  logic [tlbpt_pkg::TlbEntries-1:0] valid_q;
  tlbpt_pkg::tlb_idx_t slot_q, slot_d;

  // Lowest matching slot wins.
  always_comb begin
    res_o = '0;
    for (int i = tlbpt_pkg::TlbEntries - 1; i >= 0; i--) begin
      if (valid_q[i] && (page_q[i] == page_i)) begin
        res_o.hit   = 1'b1;
        res_o.frame = frame_q[i];
      end
    end
  end

  always_comb begin
    if (slot_q == tlbpt_pkg::TlbIdxW'(tlbpt_pkg::TlbEntries - 1)) begin
      slot_d = '0;
    end else begin
      slot_d = slot_q + tlbpt_pkg::TlbIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      slot_q  <= '0;
    end else if (ins_i.en) begin
      valid_q[slot_q] <= 1'b1;
      slot_q          <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins_i.en) begin
      page_q[slot_q]  <= ins_i.page;
      frame_q[slot_q] <= ins_i.frame;
    end
  end

endmodule

`default_nettype wire

>>> sv/tlbpt_page_table.sv
// Page table: synchronous frame memory (registered read) plus per-page valid flops.
// Depends on tlbpt_pkg for sizes and the write-back struct.
`default_nettype none

module tlbpt_page_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  tlbpt_pkg::pidx_t  rd_idx_i,
  output tlbpt_pkg::frame_t rd_frame_o,
  input  tlbpt_pkg::pidx_t  vld_idx_i,
  output logic              vld_o,
  input  tlbpt_pkg::pt_wr_t wr_i
);

  tlbpt_pkg::frame_t mem_q [tlbpt_pkg::PageCount];
  tlbpt_pkg::frame_t rd_frame_q;
  logic [tlbpt_pkg::PageCount-1:0] vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.idx] <= wr_i.frame;
    end
    if (rd_en_i) begin
      rd_frame_q <= mem_q[rd_idx_i];
    end
  end

  // Set a page valid on its first write-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.idx] <= 1'b1;
    end
  end

  assign rd_frame_o = rd_frame_q;
  assign vld_o      = vld_q[vld_idx_i];

endmodule

`default_nettype wire

>>> sv/tlbpt_tlb_page_table_translate_top.sv
// Top level of the TLB / page table translator; uses tlbpt_pkg, tlbpt_tlb, tlbpt_page_table.
// Flow: an accepted beat starts the registered read of the page table memory; the resolve
//   state then writes back the memory, the TLB and the frame counter and loads the output
//   register, and can be held by a stalled output. No new beat is taken until it completes.
// Reset: asynchronous, active low; clears TLB and page valid bits, the fill slot, the free
//   frame counter and the handshake state. The block accepts beats right after reset.
`default_nettype none

module tlb_page_table_translate_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] virtual_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] physical_address_o,
  output logic        tlb_hit_o,
  output logic        page_fault_o
);

  // One-hot sequencer: idle (ready for a beat) and resolve (page table data is back).
  typedef enum logic [1:0] {
    StIdle    = 2'b01,
    StResolve = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic                in_accept;
  logic                out_free;
  logic                resolve_go;
  logic [15:0]         va_q;
  tlbpt_pkg::page_t    page;
  tlbpt_pkg::pidx_t    rd_idx;
  tlbpt_pkg::pidx_t    cur_idx;
  tlbpt_pkg::frame_t   pt_frame;
  logic                pt_vld;
  tlbpt_pkg::tlb_res_t tlb_res;
  tlbpt_pkg::tlb_ins_t tlb_ins;
  tlbpt_pkg::pt_wr_t   pt_wr;
  tlbpt_pkg::frame_t   frame;
  logic                fault;
  tlbpt_pkg::frame_t   next_free_q, next_free_d;

  logic                out_valid_q;
  logic [15:0]         phys_q;
  logic                hit_q;
  logic                fault_q;

  // Take a beat only when no translation is in flight. The output register
  // parts the two sides, so a waiting result does not block acceptance.
  assign in_stall_o = (state_q != StIdle);
  assign in_accept  = in_valid_i && !in_stall_o;

  // The output register can take a new result when empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;

  // Commit all state updates in the same cycle the result is loaded, so a
  // stalled output never causes an update to be applied twice.
  assign resolve_go = (state_q == StResolve) && out_free;

  // Issue the page table read straight from the input port on acceptance;
  // the data is back in the resolve cycle. Writes happen only in resolve, and
  // the next read is issued no earlier than the following idle cycle, so the
  // same entry is never read and written in one cycle.
  assign rd_idx  = tlbpt_pkg::PidxLut[virtual_address_i[15:8]];

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      va_q <= virtual_address_i;
    end
  end

  assign page    = va_q[15:8];
  assign cur_idx = tlbpt_pkg::PidxLut[page];

  tlbpt_page_table u_page_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_accept),
    .rd_idx_i   (rd_idx),
    .rd_frame_o (pt_frame),
    .vld_idx_i  (cur_idx),
    .vld_o      (pt_vld),
    .wr_i       (pt_wr)
  );

  tlbpt_tlb u_tlb (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .page_i (page),
    .res_o  (tlb_res),
    .ins_i  (tlb_ins)
  );

  // Pick the frame: TLB hit first, then a valid page table entry, else
  // allocate the next free frame and flag the fault.
  always_comb begin
    fault = !tlb_res.hit && !pt_vld;
    if (tlb_res.hit) begin
      frame = tlb_res.frame;
    end else if (pt_vld) begin
      frame = pt_frame;
    end else begin
      frame = next_free_q;
    end
  end

  // Write back the page table on a fault, insert into the TLB on any miss.
  always_comb begin
    pt_wr.en      = resolve_go && fault;
    pt_wr.idx     = cur_idx;
    pt_wr.frame   = next_free_q;
    tlb_ins.en    = resolve_go && !tlb_res.hit;
    tlb_ins.page  = page;
    tlb_ins.frame = frame;
  end

  // Hand out frames in increasing order, wrapping after the last one.
  assign next_free_d = next_free_q + tlbpt_pkg::FrameW'(1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          state_d = StResolve;
        end
      end
      StResolve: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      next_free_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pt_wr.en) begin
        next_free_q <= next_free_d;
      end
      // Hold the result while stalled, drop it once taken, load a new one.
      if (resolve_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (resolve_go) begin
      phys_q  <= {frame, va_q[7:0]};
      hit_q   <= tlb_res.hit;
      fault_q <= fault;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign physical_address_o = phys_q;
  assign tlb_hit_o          = hit_q;
  assign page_fault_o       = fault_q;

  // A hit never allocates a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(tlb_hit_o && page_fault_o))
    else $error("fault flagged on a TLB hit");

  // An accepted beat blocks the next one while the translation is in resolve.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("beat accepted while a translation is in flight");

  // A committed fault advances the free frame counter by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (resolve_go && fault) |=>
      (next_free_q == tlbpt_pkg::FrameW'($past(next_free_q) + tlbpt_pkg::FrameW'(1))))
    else $error("free frame counter did not advance on a fault");

  // A committed result is presented at the output on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    resolve_go |=> (out_valid_o && (state_q == StIdle)))
    else $error("resolved translation not presented");

endmodule

`default_nettype wire
